// File: hdl/nap_pkg.sv
// Shared types, fixed-point constants and the rounding multiply for the airfoil profile block.
// Used by every module under hdl; depends on nothing else.
package nap_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FX_W      = 32;
  localparam int POS_W     = 17;
  localparam int CODE_W    = 17;
  localparam int CAM_W     = 18;
  localparam int THK_W     = 17;
  localparam int STAT_W    = 2;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_ONE = fx_t'(64'd1 << FRAC_BITS);

  // Square root pipeline: one result bit per stage, then a rounding stage.
  localparam int SQ_STEPS = (POS_W + FRAC_BITS + 1) / 2;
  localparam int SQ_LAT   = SQ_STEPS + 1;
  // Register stages from the captured position to the finished heights.
  localparam int LAT      = SQ_LAT + 3;
  localparam int CAM_LAT  = 6;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] ST_LOW     = 2'd2;

  typedef enum logic [1:0] {
    CM_NONE = 2'd0,
    CM_FOUR = 2'd1,
    CM_STD  = 2'd2,
    CM_REF  = 2'd3
  } cmode_t;

  // Decoded profile; the user keeps it stable while items are in flight, not enforced.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    cmode_t            mode;
    fx_t               tq;      // ten times the thickness ratio
    fx_t               p;       // four-digit camber position
    fx_t               p2;      // 2 p
    fx_t               omp2;    // 1 - 2 p
    fx_t               cf;      // forward parabola scale
    fx_t               ca;      // aft parabola scale
    fx_t               r;       // five-digit transition point
    fx_t               k6;
    fx_t               k21;
    fx_t               kq;      // k21 * (1 - r)^3
    fx_t               r3;
    fx_t               c3r;     // 3 r
    fx_t               c3r2r3;  // 3 r^2 - r^3
    fx_t               k6r3;    // k6 * r^3
  } cfg_t;

  // Thickness polynomial coefficients.
  localparam fx_t C_SQ = fx_t'(((64'd2969 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam fx_t C_X1 = fx_t'(((64'd126 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam fx_t C_X2 = fx_t'(((64'd3516 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam fx_t C_X3 = fx_t'(((64'd2843 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam fx_t C_X4 = fx_t'(((64'd1015 << FRAC_BITS) + 64'd5000) / 64'd10000);

  // Five-digit prefixes: standard first, reflexed after.
  localparam logic [9:0] FIVE_PREFIX [0:8] = '{
    10'd210, 10'd220, 10'd230, 10'd240, 10'd250, 10'd221, 10'd231, 10'd241, 10'd251
  };
  localparam fx_t FIVE_R [0:8] = '{
    fx_t'(((64'd58 << FRAC_BITS) + 64'd500) / 64'd1000),
    fx_t'(((64'd126 << FRAC_BITS) + 64'd500) / 64'd1000),
    fx_t'(((64'd2025 << FRAC_BITS) + 64'd5000) / 64'd10000),
    fx_t'(((64'd29 << FRAC_BITS) + 64'd50) / 64'd100),
    fx_t'(((64'd391 << FRAC_BITS) + 64'd500) / 64'd1000),
    fx_t'(((64'd13 << FRAC_BITS) + 64'd50) / 64'd100),
    fx_t'(((64'd217 << FRAC_BITS) + 64'd500) / 64'd1000),
    fx_t'(((64'd318 << FRAC_BITS) + 64'd500) / 64'd1000),
    fx_t'(((64'd441 << FRAC_BITS) + 64'd500) / 64'd1000)
  };
  localparam fx_t FIVE_K6 [0:8] = '{
    fx_t'(((64'd3614 << FRAC_BITS) + 64'd30) / 64'd60),
    fx_t'(((64'd5164 << FRAC_BITS) + 64'd300) / 64'd600),
    fx_t'(((64'd15957 << FRAC_BITS) + 64'd3000) / 64'd6000),
    fx_t'(((64'd6643 << FRAC_BITS) + 64'd3000) / 64'd6000),
    fx_t'(((64'd323 << FRAC_BITS) + 64'd300) / 64'd600),
    fx_t'(((64'd5199 << FRAC_BITS) + 64'd300) / 64'd600),
    fx_t'(((64'd15793 << FRAC_BITS) + 64'd3000) / 64'd6000),
    fx_t'(((64'd652 << FRAC_BITS) + 64'd300) / 64'd600),
    fx_t'(((64'd3191 << FRAC_BITS) + 64'd3000) / 64'd6000)
  };
  localparam fx_t FIVE_K21 [0:8] = '{
    fx_t'(0), fx_t'(0), fx_t'(0), fx_t'(0), fx_t'(0),
    fx_t'(((64'd764 << FRAC_BITS) + 64'd500000) / 64'd1000000),
    fx_t'(((64'd677 << FRAC_BITS) + 64'd50000) / 64'd100000),
    fx_t'(((64'd303 << FRAC_BITS) + 64'd5000) / 64'd10000),
    fx_t'(((64'd1355 << FRAC_BITS) + 64'd5000) / 64'd10000)
  };

  // Signed multiply, rounded to nearest on the magnitude with ties away from zero.
  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    logic              neg;
    logic [FX_W-1:0]   ma;
    logic [FX_W-1:0]   mb;
    logic [2*FX_W-1:0] prod;
    neg  = a[FX_W-1] ^ b[FX_W-1];
    ma   = a[FX_W-1] ? FX_W'(-a) : FX_W'(a);
    mb   = b[FX_W-1] ? FX_W'(-b) : FX_W'(b);
    prod = ((2*FX_W)'(ma) * (2*FX_W)'(mb) + ((2*FX_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -fx_t'(prod[FX_W-1:0]) : fx_t'(prod[FX_W-1:0]);
  endfunction

endpackage

// File: hdl/naca_airfoil_profile.sv
// Top level of the NACA four- and five-digit airfoil profile evaluator.
// Depends on nap_pkg, nap_cfg, nap_thick and nap_camber.
//
//   channel  direction  handshake                 payload
//   s_*      in         s_tvalid / s_tready       tdata = chord_pos
//   m_*      out        m_tvalid / m_tready       tdata = camber_height, full_thickness;
//                                                  tuser = status
//   cfg_*    in         cfg_valid / cfg_ready     cfg_data = profile_code
//
// One item is taken per clock while the output queue has room. A result
// reaches the output through one capture stage, eighteen stages of the square
// root unit and three more for the square root term, the sum and the thickness
// scale. Reset clears the designation to 0009 and empties the pipeline.
// The pipeline moves as a whole and holds while the two-entry output queue
// is full, so one result can wait there while new items still come in.
module naca_airfoil_profile
  import nap_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,    // [16:0] chord_pos
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,    // [17:0] camber_height, [34:18] full_thickness
  output logic [STAT_W-1:0] m_tuser,    // [1:0] status
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CODE_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic             ce;
  logic [POS_W-1:0] x0;
  logic [LAT:0]     v;
  fx_t              cam;
  fx_t              th;

  // Two-entry output queue.
  logic [1:0]        count;
  logic [39:0]       q0_data, q1_data;
  logic [STAT_W-1:0] q0_stat, q1_stat;
  logic              push, pop;
  logic [39:0]       din_data;
  logic [CAM_W-1:0]  cam_sat;
  logic [THK_W-1:0]  th_sat;

  // Designation register, always ready; the user writes it only while idle, not enforced.
  assign cfg_ready = 1'b1;

  nap_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Whole pipeline advances unless the queue is full.
  assign ce       = (count != 2'd2);
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (ce) begin
      x0 <= s_tdata[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[LAT-1:0], s_tvalid};
    end
  end

  nap_thick u_thick (
    .clk (clk),
    .ce  (ce),
    .x   (x0),
    .cfg (cfg),
    .th  (th)
  );

  nap_camber u_camber (
    .clk (clk),
    .ce  (ce),
    .x   (x0),
    .cfg (cfg),
    .cam (cam)
  );

  // Saturate to the output ranges; negative thickness clamps to zero.
  always_comb begin
    if (cam > fx_t'(65536)) begin
      cam_sat = CAM_W'(65536);
    end else if (cam < -fx_t'(65536)) begin
      cam_sat = CAM_W'(-65536);
    end else begin
      cam_sat = cam[CAM_W-1:0];
    end
    if (th < 0) begin
      th_sat = '0;
    end else if (th > fx_t'(131071)) begin
      th_sat = THK_W'(131071);
    end else begin
      th_sat = th[THK_W-1:0];
    end
    din_data = {5'b0, th_sat, cam_sat};
  end

  assign push     = ce && v[LAT];
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = q0_data;
  assign m_tuser  = q0_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          q0_data <= din_data;
          q0_stat <= cfg.status;
        end
      end
      2'd1: begin
        if (push && pop) begin
          q0_data <= din_data;
          q0_stat <= cfg.status;
        end else if (push) begin
          q1_data <= din_data;
          q1_stat <= cfg.status;
        end
      end
      2'd2: begin
        if (pop) begin
          q0_data <= q1_data;
          q0_stat <= q1_stat;
        end
      end
      default: begin
      end
    endcase
  end

  // The queue never holds more than two results.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output queue overflow");

  // A held pipeline keeps its valid bits.
  a_hold: assert property (@(posedge clk) disable iff (rst) !ce |=> $stable(v))
    else $error("pipeline moved while held");

  // A code below one always gives zero heights.
  a_low_zero: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == ST_LOW) |-> (m_tdata == '0))
    else $error("nonzero result for a code below one");

endmodule

// File: hdl/nap_cfg.sv
// Designation register and its decode into camber law and constants.
// Depends on nap_pkg.
module nap_cfg
  import nap_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CODE_W-1:0] wr_data,
  output cfg_t              cfg
);

  logic [CODE_W-1:0] profile_code;
  cfg_t              cfg_next;

  fx_t tq_tab [0:99];
  fx_t p_tab  [0:9];
  fx_t cf_tab [0:9][0:9];
  fx_t ca_tab [0:9][0:9];
  fx_t f_r2r3 [0:8];
  fx_t f_r3   [0:8];
  fx_t f_kq   [0:8];
  fx_t f_k6r3 [0:8];

  for (genvar T = 0; T < 100; T++) begin : g_tq
    localparam logic [63:0] V = ((64'(T) << FRAC_BITS) + 64'd5) / 64'd10;
    assign tq_tab[T] = fx_t'(V);
  end

  for (genvar N1 = 0; N1 < 10; N1++) begin : g_n1
    for (genvar N2 = 0; N2 < 10; N2++) begin : g_n2
      localparam int DF = (N2 == 0) ? 1 : N2 * N2;
      localparam int DA = (10 - N2) * (10 - N2);
      localparam logic [63:0] VF = ((64'(N1) << FRAC_BITS) + 64'(DF / 2)) / 64'(DF);
      localparam logic [63:0] VA = ((64'(N1) << FRAC_BITS) + 64'(DA / 2)) / 64'(DA);
      assign cf_tab[N1][N2] = fx_t'(VF);
      assign ca_tab[N1][N2] = fx_t'(VA);
    end
    localparam logic [63:0] VP = ((64'(N1) << FRAC_BITS) + 64'd5) / 64'd10;
    assign p_tab[N1] = fx_t'(VP);
  end

  for (genvar E = 0; E < 9; E++) begin : g_five
    localparam fx_t R2 = fx_mul(FIVE_R[E], FIVE_R[E]);
    localparam fx_t R3 = fx_mul(R2, FIVE_R[E]);
    localparam fx_t Q  = FX_ONE - FIVE_R[E];
    localparam fx_t Q3 = fx_mul(fx_mul(Q, Q), Q);
    assign f_r3[E]   = R3;
    assign f_r2r3[E] = fx_t'(3) * R2 - R3;
    assign f_kq[E]   = fx_mul(FIVE_K21[E], Q3);
    assign f_k6r3[E] = fx_mul(FIVE_K6[E], R3);
  end

  // Digit split by reciprocal multiplication; exact over the code range.
  logic [34:0] q_prod;
  logic [9:0]  hund;
  logic [6:0]  t100;
  logic [17:0] n1_prod;
  logic [3:0]  n1;
  logic [3:0]  n2;
  logic        found;
  logic [3:0]  idx;

  always_comb begin
    q_prod  = 35'(profile_code) * 35'd167773;
    hund    = q_prod[33:24];
    t100    = 7'(profile_code - CODE_W'(hund) * CODE_W'(100));
    n1_prod = 18'(hund) * 18'd205;
    n1      = n1_prod[14:11];
    n2      = 4'(hund - 10'(n1) * 10'd10);
    found   = 1'b0;
    idx     = '0;
    for (int i = 0; i < 9; i++) begin
      if (hund == FIVE_PREFIX[i]) begin
        found = 1'b1;
        idx   = 4'(i);
      end
    end

    cfg_next        = '0;
    cfg_next.status = ST_OK;
    cfg_next.mode   = CM_NONE;
    if (profile_code == '0) begin
      cfg_next.status = ST_LOW;
    end else if (profile_code > CODE_W'(10000)) begin
      if (found) begin
        cfg_next.tq     = tq_tab[t100];
        cfg_next.mode   = (FIVE_K21[idx] == '0) ? CM_STD : CM_REF;
        cfg_next.r      = FIVE_R[idx];
        cfg_next.k6     = FIVE_K6[idx];
        cfg_next.k21    = FIVE_K21[idx];
        cfg_next.kq     = f_kq[idx];
        cfg_next.r3     = f_r3[idx];
        cfg_next.c3r    = fx_t'(3) * FIVE_R[idx];
        cfg_next.c3r2r3 = f_r2r3[idx];
        cfg_next.k6r3   = f_k6r3[idx];
      end else begin
        cfg_next.status = ST_UNKNOWN;
        cfg_next.tq     = tq_tab[9];
      end
    end else begin
      cfg_next.tq = tq_tab[t100];
      if (n1 != '0 && n1 < 4'd10 && n2 != '0) begin
        cfg_next.mode = CM_FOUR;
        cfg_next.p    = p_tab[n2];
        cfg_next.p2   = p_tab[n2] <<< 1;
        cfg_next.omp2 = FX_ONE - (p_tab[n2] <<< 1);
        cfg_next.cf   = cf_tab[n1][n2];
        cfg_next.ca   = ca_tab[n1][n2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      profile_code <= CODE_W'(9);
    end else if (wr_en) begin
      profile_code <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

endmodule

// File: hdl/nap_sqrt.sv
// Pipelined square root of a chord position, one result bit per stage, rounded to nearest.
// Depends on nap_pkg.
module nap_sqrt
  import nap_pkg::*;
(
  input  logic             clk,
  input  logic             ce,
  input  logic [POS_W-1:0] x,
  output fx_t              sq
);

  localparam int IN_W  = 2 * SQ_STEPS;
  localparam int REM_W = SQ_STEPS + 3;

  logic [IN_W-1:0]     rad  [0:SQ_STEPS];
  logic [SQ_STEPS-1:0] root [0:SQ_STEPS];
  logic [REM_W-1:0]    rem  [0:SQ_STEPS];

  assign rad[0]  = IN_W'({x, {FRAC_BITS{1'b0}}});
  assign root[0] = '0;
  assign rem[0]  = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [REM_W-1:0]    rs;
    logic [REM_W-1:0]    trial;
    logic [REM_W-1:0]    rem_n;
    logic [SQ_STEPS-1:0] root_n;

    always_comb begin
      rs    = {rem[k][REM_W-3:0], rad[k][IN_W-1 -: 2]};
      trial = REM_W'({root[k], 2'b01});
      if (rs >= trial) begin
        rem_n  = rs - trial;
        root_n = {root[k][SQ_STEPS-2:0], 1'b1};
      end else begin
        rem_n  = rs;
        root_n = {root[k][SQ_STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rad[k+1]  <= rad[k] << 2;
        root[k+1] <= root_n;
        rem[k+1]  <= rem_n;
      end
    end
  end

  // Remainder above the root means the true root lies nearer the next integer.
  always_ff @(posedge clk) begin
    if (ce) begin
      if (rem[SQ_STEPS] > REM_W'(root[SQ_STEPS])) begin
        sq <= fx_t'(root[SQ_STEPS]) + fx_t'(1);
      end else begin
        sq <= fx_t'(root[SQ_STEPS]);
      end
    end
  end

endmodule

// File: hdl/nap_thick.sv
// Thickness pipeline: powers of x, polynomial terms, square root term and thickness scale.
// Depends on nap_pkg and nap_sqrt.
module nap_thick
  import nap_pkg::*;
(
  input  logic             clk,
  input  logic             ce,
  input  logic [POS_W-1:0] x,
  input  cfg_t             cfg,
  output fx_t              th
);

  localparam int PD = SQ_LAT - 5;

  fx_t xs;
  fx_t sq;
  fx_t x1, x2, a1;
  fx_t x1b, x3, a2, b2;
  fx_t x4, a3, b3, c3;
  fx_t a4, b4, c4, e4;
  fx_t part_d [0:PD];
  fx_t sterm, plate, poly;

  assign xs = fx_t'({{(FX_W-POS_W){1'b0}}, x});

  nap_sqrt u_sqrt (
    .clk (clk),
    .ce  (ce),
    .x   (x),
    .sq  (sq)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      x1  <= xs;
      x2  <= fx_mul(xs, xs);
      a1  <= fx_mul(C_X1, xs);

      x1b <= x1;
      x3  <= fx_mul(x2, x1);
      a2  <= a1;
      b2  <= fx_mul(C_X2, x2);

      x4  <= fx_mul(x3, x1b);
      a3  <= a2;
      b3  <= b2;
      c3  <= fx_mul(C_X3, x3);

      a4  <= a3;
      b4  <= b3;
      c4  <= c3;
      e4  <= fx_mul(C_X4, x4);

      part_d[0] <= c4 - a4 - b4 - e4;
      for (int k = 1; k <= PD; k++) begin
        part_d[k] <= part_d[k-1];
      end

      sterm <= fx_mul(C_SQ, sq);
      plate <= part_d[PD];
      poly  <= sterm + plate;
      th    <= fx_mul(poly, cfg.tq);
    end
  end

endmodule

// File: hdl/nap_camber.sv
// Camber pipeline: four-digit parabolas and five-digit cubic laws side by side, then a select.
// Depends on nap_pkg.
module nap_camber
  import nap_pkg::*;
(
  input  logic             clk,
  input  logic             ce,
  input  logic [POS_W-1:0] x,
  input  cfg_t             cfg,
  output fx_t              cam
);

  localparam int PD = LAT - CAM_LAT;

  fx_t  xs;
  fx_t  x1, x2, d1, twopx, t1, t2, tb1, tail1;
  logic lep1, ler1;
  fx_t  x3, t3, dd, d2, f4, cs4, tsum2, tb2, tail2;
  logic ler2;
  fx_t  d3, cam4_3, sin3, tsum3, tail3;
  logic ler3;
  fx_t  lead4, std4, cam4_4, tsum4, tail4;
  logic ler4;
  fx_t  ref5, std5, cam4_5;
  fx_t  cd [0:PD];

  assign xs  = fx_t'({{(FX_W-POS_W){1'b0}}, x});
  assign cam = cd[PD];

  always_ff @(posedge clk) begin
    if (ce) begin
      x1    <= xs;
      x2    <= fx_mul(xs, xs);
      d1    <= xs - cfg.r;
      twopx <= fx_mul(cfg.p2, xs);
      t1    <= fx_mul(cfg.kq, xs);
      t2    <= fx_mul(cfg.r3, xs - FX_ONE);
      tb1   <= fx_mul(cfg.c3r2r3, xs);
      tail1 <= fx_mul(cfg.k6r3, FX_ONE - xs);
      lep1  <= (xs <= cfg.p);
      ler1  <= (xs <= cfg.r);

      x3    <= fx_mul(x2, x1);
      t3    <= fx_mul(cfg.c3r, x2);
      dd    <= fx_mul(d1, d1);
      d2    <= d1;
      f4    <= lep1 ? (twopx - x2) : (cfg.omp2 + twopx - x2);
      cs4   <= lep1 ? cfg.cf : cfg.ca;
      tsum2 <= t1 + t2;
      tb2   <= tb1;
      tail2 <= tail1;
      ler2  <= ler1;

      d3     <= fx_mul(dd, d2);
      cam4_3 <= fx_mul(cs4, f4);
      sin3   <= x3 - t3 + tb2;
      tsum3  <= tsum2;
      tail3  <= tail2;
      ler3   <= ler2;

      lead4  <= ler3 ? d3 : fx_mul(cfg.k21, d3);
      std4   <= fx_mul(cfg.k6, sin3);
      cam4_4 <= cam4_3;
      tsum4  <= tsum3;
      tail4  <= tail3;
      ler4   <= ler3;

      ref5   <= fx_mul(cfg.k6, lead4 - tsum4);
      std5   <= ler4 ? std4 : tail4;
      cam4_5 <= cam4_4;

      case (cfg.mode)
        CM_FOUR: cd[0] <= cam4_5;
        CM_STD:  cd[0] <= std5;
        CM_REF:  cd[0] <= ref5;
        default: cd[0] <= '0;
      endcase
      for (int k = 1; k <= PD; k++) begin
        cd[k] <= cd[k-1];
      end
    end
  end

endmodule
